@@ hw/rtl/gaussian_conv_5x5_stream_assert.svh @@
// Assertion helpers for the 5x5 Gaussian stream filter.
// Both expect clk and rst_n in scope and are disabled while reset is low.
`ifndef GAUSSIAN_CONV_5X5_STREAM_ASSERT_SVH
`define GAUSSIAN_CONV_5X5_STREAM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GC5_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GC5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gc5_pkg.sv @@
package gc5_pkg;

  localparam int KERNEL_DIM    = 5;
  localparam int LB_ROWS       = KERNEL_DIM - 1;
  localparam int MAX_PAD_WIDTH = 64;

  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 7;
  localparam int HEIGHT_W = 12;
  localparam int COEF_W   = 16;
  localparam int COL_W    = $clog2(MAX_PAD_WIDTH);
  localparam int ROW_W    = 12;
  localparam int RAW_W    = 29;
  localparam int FILT_W   = 13;
  localparam int LB_W     = LB_ROWS * PIX_W;

  // Sums of four and of eight pixels sharing one coefficient.
  localparam int GRP4_W = PIX_W + 2;
  localparam int GRP8_W = PIX_W + 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_PADDED_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PADDED_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CORNER       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OUTER_NEAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OUTER_MID    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_INNER_CORNER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_INNER_MID    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER       = 3'd7;

  localparam logic [WIDTH_W-1:0]  RST_PADDED_WIDTH      = 7'd14;
  localparam logic [HEIGHT_W-1:0] RST_PADDED_HEIGHT     = 12'd14;
  localparam logic [COEF_W-1:0]   RST_COEF_CORNER       = 16'd256;
  localparam logic [COEF_W-1:0]   RST_COEF_OUTER_NEAR   = 16'd1022;
  localparam logic [COEF_W-1:0]   RST_COEF_OUTER_MID    = 16'd1534;
  localparam logic [COEF_W-1:0]   RST_COEF_INNER_CORNER = 16'd4096;
  localparam logic [COEF_W-1:0]   RST_COEF_INNER_MID    = 16'd6147;
  localparam logic [COEF_W-1:0]   RST_COEF_CENTER       = 16'd9227;

  localparam logic [WIDTH_W-1:0]  MIN_PAD_WIDTH  = 7'(KERNEL_DIM);
  localparam logic [WIDTH_W-1:0]  MAX_WIDTH_VAL  = 7'(MAX_PAD_WIDTH);
  localparam logic [HEIGHT_W-1:0] MIN_PAD_HEIGHT = 12'(KERNEL_DIM);

  // Rounding constant for Q13.16 to integer, half up.
  localparam int FRAC_W = 16;
  localparam logic [RAW_W:0] ROUND_HALF = (RAW_W + 1)'(1) << (FRAC_W - 1);

  // Position and end-of-frame mark travelling alongside each word.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } tag_t;

endpackage

@@ hw/rtl/gc5_stream_if.sv @@
interface gc5_pix_if;
  import gc5_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface gc5_res_if;
  import gc5_pkg::*;

  logic              valid;
  logic              ready;
  logic [FILT_W-1:0] filtered_pixel;
  logic [RAW_W-1:0]  raw_sum;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic              frame_last;

  modport source (
    output valid, output filtered_pixel, output raw_sum, output out_row,
    output out_col, output frame_last, input ready
  );
  modport sink (
    input valid, input filtered_pixel, input raw_sum, input out_row,
    input out_col, input frame_last, output ready
  );
endinterface

@@ hw/rtl/gaussian_conv_5x5_stream.sv @@
// Channel   Dir  Handshake      Word
// in_ch     in   valid/ready    pixel (8 bits, padded raster order)
// out_ch    out  valid/ready    filtered_pixel, raw_sum, out_row, out_col, frame_last
// cfg_*     in   write enable   cfg_index selects one of eight registers
//
// One pixel is accepted every cycle while the pipe can move; results leave from a register.
// The line buffer is a single 64 x 32-bit memory read one column ahead of the pixel.
// The stages behind the window close up bubbles, so only a stalled full pipe stops input.
// Synchronous active-low reset clears counters, window and valids and loads the default
// configuration registers; the line buffer is not cleared and needs no pass after reset.
module gaussian_conv_5x5_stream (
  input  logic                             clk,
  input  logic                             rst_n,
  gc5_pix_if.sink                          in_ch,
  gc5_res_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [gc5_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gc5_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gc5_pkg::*;

  // Configuration registers
  logic [WIDTH_W-1:0]  pad_width_r;
  logic [HEIGHT_W-1:0] pad_height_r;
  logic [COEF_W-1:0]   c_corner_r, c_near_r, c_mid_r, c_icorner_r, c_imid_r, c_center_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_width_r  <= RST_PADDED_WIDTH;
      pad_height_r <= RST_PADDED_HEIGHT;
      c_corner_r   <= RST_COEF_CORNER;
      c_near_r     <= RST_COEF_OUTER_NEAR;
      c_mid_r      <= RST_COEF_OUTER_MID;
      c_icorner_r  <= RST_COEF_INNER_CORNER;
      c_imid_r     <= RST_COEF_INNER_MID;
      c_center_r   <= RST_COEF_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PADDED_WIDTH:      pad_width_r  <= cfg_wdata[WIDTH_W-1:0];
        REG_PADDED_HEIGHT:     pad_height_r <= cfg_wdata[HEIGHT_W-1:0];
        REG_COEF_CORNER:       c_corner_r   <= cfg_wdata;
        REG_COEF_OUTER_NEAR:   c_near_r     <= cfg_wdata;
        REG_COEF_OUTER_MID:    c_mid_r      <= cfg_wdata;
        REG_COEF_INNER_CORNER: c_icorner_r  <= cfg_wdata;
        REG_COEF_INNER_MID:    c_imid_r     <= cfg_wdata;
        REG_COEF_CENTER:       c_center_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control: each stage moves when it is empty or its successor moves.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en_out;
  logic in_acc;

  assign en_out = !out_valid_r || out_ch.ready;
  assign en4    = !v4_r || en_out;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign in_ch.ready = en1;
  assign in_acc = in_ch.valid && en1;

  // Frame counters
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [WIDTH_W-1:0]  width_m1;
  logic [HEIGHT_W-1:0] height_m1;
  logic                col_wrap, row_wrap, has_result;

  always_comb begin
    if (pad_width_r < MIN_PAD_WIDTH) begin
      width_m1 = MIN_PAD_WIDTH - WIDTH_W'(1);
    end else if (pad_width_r > MAX_WIDTH_VAL) begin
      width_m1 = MAX_WIDTH_VAL - WIDTH_W'(1);
    end else begin
      width_m1 = pad_width_r - WIDTH_W'(1);
    end
    if (pad_height_r < MIN_PAD_HEIGHT) begin
      height_m1 = MIN_PAD_HEIGHT - HEIGHT_W'(1);
    end else begin
      height_m1 = pad_height_r - HEIGHT_W'(1);
    end
    col_wrap   = {1'b0, col_r} >= width_m1;
    row_wrap   = row_r >= height_m1;
    has_result = (row_r >= ROW_W'(LB_ROWS)) && (col_r >= COL_W'(LB_ROWS));
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line buffer: byte i of an entry is line row i, oldest in the low byte.
  // The read address runs one column ahead, so the data is ready when the pixel arrives.
  logic [LB_W-1:0] lb_mem [MAX_PAD_WIDTH];
  logic [LB_W-1:0] lb_q_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lb_mem[col_r] <= {in_ch.pixel, lb_q_r[LB_W-1:PIX_W]};
    end
    lb_q_r <= lb_mem[col_nxt];
  end

  // Window, stage 1
  logic [PIX_W-1:0] win_r [KERNEL_DIM][KERNEL_DIM];
  logic [PIX_W-1:0] column [KERNEL_DIM];
  tag_t             tag1_r;
  logic             v1_nxt;

  always_comb begin
    for (int i = 0; i < LB_ROWS; i++) begin
      column[i] = lb_q_r[i*PIX_W +: PIX_W];
    end
    column[LB_ROWS] = in_ch.pixel;
    if (in_acc) begin
      v1_nxt = has_result;
    end else if (en2) begin
      v1_nxt = 1'b0;
    end else begin
      v1_nxt = v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      for (int i = 0; i < KERNEL_DIM; i++) begin
        for (int j = 0; j < KERNEL_DIM; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      v1_r <= v1_nxt;
      if (in_acc) begin
        for (int i = 0; i < KERNEL_DIM; i++) begin
          for (int j = 0; j < KERNEL_DIM - 1; j++) begin
            win_r[i][j] <= win_r[i][j+1];
          end
          win_r[i][KERNEL_DIM-1] <= column[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag1_r.row  <= row_r - ROW_W'(LB_ROWS);
      tag1_r.col  <= col_r - COL_W'(LB_ROWS);
      tag1_r.last <= row_wrap && col_wrap;
    end
  end

  // Stage 2: pixels sharing a coefficient are added first, as the kernel is symmetric.
  logic [GRP4_W-1:0] g_corner_nxt, g_mid_nxt, g_icorner_nxt, g_imid_nxt;
  logic [GRP8_W-1:0] g_near_nxt;
  logic [GRP4_W-1:0] g_corner_r, g_mid_r, g_icorner_r, g_imid_r;
  logic [GRP8_W-1:0] g_near_r;
  logic [PIX_W-1:0]  g_center_r;
  tag_t              tag2_r;

  always_comb begin
    g_corner_nxt  = GRP4_W'(win_r[0][0]) + GRP4_W'(win_r[0][4])
                  + GRP4_W'(win_r[4][0]) + GRP4_W'(win_r[4][4]);
    g_near_nxt    = GRP8_W'(win_r[0][1]) + GRP8_W'(win_r[0][3])
                  + GRP8_W'(win_r[4][1]) + GRP8_W'(win_r[4][3])
                  + GRP8_W'(win_r[1][0]) + GRP8_W'(win_r[3][0])
                  + GRP8_W'(win_r[1][4]) + GRP8_W'(win_r[3][4]);
    g_mid_nxt     = GRP4_W'(win_r[0][2]) + GRP4_W'(win_r[4][2])
                  + GRP4_W'(win_r[2][0]) + GRP4_W'(win_r[2][4]);
    g_icorner_nxt = GRP4_W'(win_r[1][1]) + GRP4_W'(win_r[1][3])
                  + GRP4_W'(win_r[3][1]) + GRP4_W'(win_r[3][3]);
    g_imid_nxt    = GRP4_W'(win_r[1][2]) + GRP4_W'(win_r[3][2])
                  + GRP4_W'(win_r[2][1]) + GRP4_W'(win_r[2][3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      g_corner_r  <= g_corner_nxt;
      g_near_r    <= g_near_nxt;
      g_mid_r     <= g_mid_nxt;
      g_icorner_r <= g_icorner_nxt;
      g_imid_r    <= g_imid_nxt;
      g_center_r  <= win_r[2][2];
      tag2_r      <= tag1_r;
    end
  end

  // Stage 3: one product per coefficient
  localparam int P4_W = COEF_W + GRP4_W;
  localparam int P8_W = COEF_W + GRP8_W;
  localparam int P1_W = COEF_W + PIX_W;

  logic [P4_W-1:0] p_corner_r, p_mid_r, p_icorner_r, p_imid_r;
  logic [P8_W-1:0] p_near_r;
  logic [P1_W-1:0] p_center_r;
  tag_t            tag3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      p_corner_r  <= P4_W'(c_corner_r)  * P4_W'(g_corner_r);
      p_near_r    <= P8_W'(c_near_r)    * P8_W'(g_near_r);
      p_mid_r     <= P4_W'(c_mid_r)     * P4_W'(g_mid_r);
      p_icorner_r <= P4_W'(c_icorner_r) * P4_W'(g_icorner_r);
      p_imid_r    <= P4_W'(c_imid_r)    * P4_W'(g_imid_r);
      p_center_r  <= P1_W'(c_center_r)  * P1_W'(g_center_r);
      tag3_r      <= tag2_r;
    end
  end

  // Stage 4: pairwise sums
  logic [RAW_W-1:0] s_a_r, s_b_r, s_c_r;
  tag_t             tag4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s_a_r  <= RAW_W'(p_corner_r)  + RAW_W'(p_near_r);
      s_b_r  <= RAW_W'(p_mid_r)     + RAW_W'(p_icorner_r);
      s_c_r  <= RAW_W'(p_imid_r)    + RAW_W'(p_center_r);
      tag4_r <= tag3_r;
    end
  end

  // Output register: final sum and its rounded integer part
  logic [RAW_W-1:0]  raw_nxt;
  logic [RAW_W:0]    rnd_sum;
  logic [RAW_W-1:0]  raw_r;
  logic [FILT_W-1:0] filt_r;
  tag_t              tag_out_r;

  always_comb begin
    raw_nxt = s_a_r + s_b_r + s_c_r;
    rnd_sum = {1'b0, raw_nxt} + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      raw_r     <= raw_nxt;
      filt_r    <= rnd_sum[FRAC_W +: FILT_W];
      tag_out_r <= tag4_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_pixel = filt_r;
  assign out_ch.raw_sum        = raw_r;
  assign out_ch.out_row        = tag_out_r.row;
  assign out_ch.out_col        = tag_out_r.col;
  assign out_ch.frame_last     = tag_out_r.last;

`include "gaussian_conv_5x5_stream_assert.svh"

  `GC5_ASSERT_NEXT(a_col_step, in_acc && !col_wrap, col_r == $past(col_r) + COL_W'(1), "column did not advance")
  `GC5_ASSERT_NEXT(a_col_wrap, in_acc && col_wrap, col_r == '0, "column did not wrap at row end")
  `GC5_ASSERT_NEXT(a_idle_hold, !in_acc, $stable(col_r) && $stable(row_r), "counters moved without a word")
  `GC5_ASSERT_SAME(a_win_taken, in_acc && v1_r, en2, "window overwritten before stage two took it")
  `GC5_ASSERT_NEXT(a_v1_hold, v1_r && !en2, v1_r, "pending window result lost")

endmodule
